// ===== src/zlhp_pkg.sv =====
// zlhp_pkg: shared types, codes and helpers of the zip local header parser
// no dependencies; used by every module of the block
`default_nettype none

package zlhp_pkg;

	// default build constants
	localparam int MAX_NAME_BYTES_DEF = 32;
	localparam int QUEUE_DEPTH_DEF    = 2;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_LEN  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NAME_TOTAL = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NAME_0     = 3'd2;

	// result status codes
	localparam logic [2:0] ST_CONSUMED = 3'd0;
	localparam logic [2:0] ST_COMPLETE = 3'd1;
	localparam logic [2:0] ST_CENTRAL  = 3'd2;
	localparam logic [2:0] ST_ERROR    = 3'd3;
	localparam logic [2:0] ST_METHOD   = 3'd4;
	localparam logic [2:0] ST_ENDED    = 3'd5;

	// signature and method bytes
	localparam logic [7:0] BYTE_P    = 8'h50;
	localparam logic [7:0] BYTE_K    = 8'h4B;
	localparam logic [7:0] BYTE_01   = 8'h01;
	localparam logic [7:0] BYTE_02   = 8'h02;
	localparam logic [7:0] BYTE_03   = 8'h03;
	localparam logic [7:0] BYTE_04   = 8'h04;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	// class of a stream byte as seen by the parser
	typedef enum logic [2:0] {
		BC_OTHER,
		BC_ZERO,
		BC_P,
		BC_K,
		BC_01,
		BC_02,
		BC_03,
		BC_04
	} byte_class_t;

	// input transaction
	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic [2:0]  status;
		logic        name_matched;
		logic [31:0] entry_crc;
		logic [31:0] packed_size;
		logic [31:0] plain_size;
	} out_item_t;

	// classified item passed from front to back
	typedef struct packed {
		logic        restart;
		logic [7:0]  data_byte;
		logic [7:0]  folded_byte;
		byte_class_t byte_class;
	} q_item_t;

	// queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// ascii upper case to lower case
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/zlhp_front.sv =====
// zlhp_front: input register stage, byte classification and case folding
// depends on zlhp_pkg; feeds zlhp_queue
`default_nettype none

module zlhp_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire zlhp_pkg::in_item_t  item,
	output logic                     push,
	output zlhp_pkg::q_item_t        push_item,
	input  wire zlhp_pkg::q_status_t q_stat
);

	logic                  valid_s1;
	zlhp_pkg::q_item_t     item_s1;
	zlhp_pkg::q_item_t     cls_item;
	zlhp_pkg::byte_class_t cls;

	// classify the incoming byte
	always_comb begin
		unique case (item.data_byte)
			zlhp_pkg::BYTE_ZERO: cls = zlhp_pkg::BC_ZERO;
			zlhp_pkg::BYTE_P:    cls = zlhp_pkg::BC_P;
			zlhp_pkg::BYTE_K:    cls = zlhp_pkg::BC_K;
			zlhp_pkg::BYTE_01:   cls = zlhp_pkg::BC_01;
			zlhp_pkg::BYTE_02:   cls = zlhp_pkg::BC_02;
			zlhp_pkg::BYTE_03:   cls = zlhp_pkg::BC_03;
			zlhp_pkg::BYTE_04:   cls = zlhp_pkg::BC_04;
			default:             cls = zlhp_pkg::BC_OTHER;
		endcase
		cls_item.restart     = item.func;
		cls_item.data_byte   = item.data_byte;
		cls_item.folded_byte = zlhp_pkg::fold_case(item.data_byte);
		cls_item.byte_class  = cls;
	end

	// hold only while the stage is full and the queue cannot take it
	assign item_stall = valid_s1 && q_stat.full;
	assign push       = valid_s1 && !q_stat.full;
	assign push_item  = item_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= cls_item;
		end
	end

endmodule

`default_nettype wire

// ===== src/zlhp_queue.sv =====
// zlhp_queue: short first-in first-out queue between front and back parts
// depends on zlhp_pkg for the item and status types
`default_nettype none

module zlhp_queue #(
	parameter int DEPTH = zlhp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire zlhp_pkg::q_item_t push_item,
	input  wire logic              pop,
	output zlhp_pkg::q_item_t      pop_item,
	output zlhp_pkg::q_status_t    q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	zlhp_pkg::q_item_t  entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_item     = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== src/zlhp_back.sv =====
// zlhp_back: header parsing state machine, configuration registers, result register
// depends on zlhp_pkg; takes classified items from zlhp_queue
`default_nettype none

module zlhp_back #(
	parameter int MAX_NAME_BYTES = zlhp_pkg::MAX_NAME_BYTES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [zlhp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [zlhp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire zlhp_pkg::q_item_t                pop_item,
	input  wire zlhp_pkg::q_status_t              q_stat,
	output logic                                  pop,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output zlhp_pkg::out_item_t                   result
);

	localparam int IDX_W = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

	typedef enum logic [3:0] {
		PH_SIGNATURE,
		PH_VERSION,
		PH_FLAG,
		PH_METHOD,
		PH_TIME,
		PH_DATE,
		PH_CRC,
		PH_CSIZE,
		PH_USIZE,
		PH_NAMELEN,
		PH_EXTRALEN,
		PH_NAME,
		PH_EXTRA,
		PH_END
	} phase_t;

	// configuration
	logic [5:0]  match_len_q;
	logic [15:0] name_total_q;
	logic [7:0]  name_q [MAX_NAME_BYTES];

	// parser state
	phase_t      phase_q,  phase_d;
	logic [15:0] pos_q,    pos_d;
	logic        sawl_q,   sawl_d;
	logic        sawc_q,   sawc_d;
	logic        still_q,  still_d;
	logic        found_q,  found_d;
	logic [31:0] crc_q,    crc_d;
	logic [31:0] csize_q,  csize_d;
	logic [31:0] usize_q,  usize_d;
	logic [15:0] nlen_q,   nlen_d;
	logic [15:0] xlen_q,   xlen_d;
	logic [2:0]  status_d;

	logic                  res_valid_q;
	zlhp_pkg::out_item_t   res_q;

	logic [15:0]           pos_inc;
	logic [16:0]           pos_ext;
	logic [5:0]            eff_len;
	logic                  in_cmp;
	logic [7:0]            wanted_f;
	logic                  still_n;
	logic [IDX_W-1:0]      name_idx;
	zlhp_pkg::byte_class_t cls;

	// take a transaction whenever the result register is free or draining
	assign pop          = !q_stat.empty && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// name compare helpers
	assign eff_len  = (match_len_q > 6'(MAX_NAME_BYTES)) ? 6'(MAX_NAME_BYTES) : match_len_q;
	assign in_cmp   = (pos_q < {10'd0, eff_len});
	assign name_idx = pos_q[IDX_W-1:0];
	assign wanted_f = in_cmp ? zlhp_pkg::fold_case(name_q[name_idx]) : 8'h00;
	assign still_n  = still_q && (nlen_q == name_total_q)
	                  && !(in_cmp && (wanted_f != pop_item.folded_byte));
	assign pos_inc  = pos_q + 16'd1;
	assign pos_ext  = {1'b0, pos_q} + 17'd1;
	assign cls      = pop_item.byte_class;

	// next state of the parser for one byte
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		sawl_d   = sawl_q;
		sawc_d   = sawc_q;
		still_d  = still_q;
		found_d  = found_q;
		crc_d    = crc_q;
		csize_d  = csize_q;
		usize_d  = usize_q;
		nlen_d   = nlen_q;
		xlen_d   = xlen_q;
		status_d = zlhp_pkg::ST_CONSUMED;
		if (pop_item.restart) begin
			phase_d = PH_SIGNATURE;
			pos_d   = '0;
			sawl_d  = 1'b0;
			sawc_d  = 1'b0;
			still_d = 1'b1;
			found_d = 1'b0;
			crc_d   = '0;
			csize_d = '0;
			usize_d = '0;
			nlen_d  = '0;
			xlen_d  = '0;
		end else if (match_len_q == '0) begin
			status_d = zlhp_pkg::ST_ERROR;
		end else begin
			unique case (phase_q)
				PH_SIGNATURE: begin
					pos_d = pos_inc;
					if (pos_inc == 16'd1 && cls == zlhp_pkg::BC_P) begin
						status_d = zlhp_pkg::ST_CONSUMED;
					end else if (pos_inc == 16'd2 && cls == zlhp_pkg::BC_K) begin
						sawl_d = 1'b0;
						sawc_d = 1'b0;
					end else if (pos_inc == 16'd3 && cls == zlhp_pkg::BC_03) begin
						sawl_d = 1'b1;
					end else if (pos_inc == 16'd3 && cls == zlhp_pkg::BC_01) begin
						sawc_d = 1'b1;
					end else if (sawc_q && pos_inc == 16'd4 && cls == zlhp_pkg::BC_02) begin
						status_d = zlhp_pkg::ST_CENTRAL;
					end else if (sawl_q && pos_inc == 16'd4 && cls == zlhp_pkg::BC_04) begin
						pos_d   = '0;
						phase_d = PH_VERSION;
					end else begin
						status_d = zlhp_pkg::ST_ERROR;
					end
				end
				PH_VERSION, PH_FLAG, PH_TIME, PH_DATE: begin
					pos_d = pos_inc;
					if (pos_inc == 16'd2) begin
						pos_d = '0;
						case (phase_q)
							PH_VERSION: phase_d = PH_FLAG;
							PH_FLAG:    phase_d = PH_METHOD;
							PH_TIME:    phase_d = PH_DATE;
							default: begin
								phase_d = PH_CRC;
								crc_d   = '0;
							end
						endcase
					end
				end
				PH_METHOD: begin
					pos_d = pos_inc;
					if (pos_inc == 16'd1 && cls != zlhp_pkg::BC_ZERO) begin
						status_d = zlhp_pkg::ST_METHOD;
					end else if (pos_inc == 16'd2) begin
						if (cls != zlhp_pkg::BC_ZERO) begin
							status_d = zlhp_pkg::ST_METHOD;
						end else begin
							pos_d   = '0;
							phase_d = PH_TIME;
						end
					end
				end
				PH_CRC: begin
					crc_d = crc_q | (32'(pop_item.data_byte) << {pos_q[1:0], 3'b000});
					pos_d = pos_inc;
					if (pos_inc == 16'd4) begin
						phase_d = PH_CSIZE;
						csize_d = '0;
						pos_d   = '0;
					end
				end
				PH_CSIZE: begin
					csize_d = csize_q | (32'(pop_item.data_byte) << {pos_q[1:0], 3'b000});
					pos_d   = pos_inc;
					if (pos_inc == 16'd4) begin
						phase_d = PH_USIZE;
						usize_d = '0;
						pos_d   = '0;
					end
				end
				PH_USIZE: begin
					usize_d = usize_q | (32'(pop_item.data_byte) << {pos_q[1:0], 3'b000});
					pos_d   = pos_inc;
					if (pos_inc == 16'd4) begin
						phase_d = PH_NAMELEN;
						nlen_d  = '0;
						pos_d   = '0;
					end
				end
				PH_NAMELEN: begin
					nlen_d = nlen_q | (16'(pop_item.data_byte) << {pos_q[0], 3'b000});
					pos_d  = pos_inc;
					if (pos_inc == 16'd2) begin
						phase_d = PH_EXTRALEN;
						xlen_d  = '0;
						pos_d   = '0;
					end
				end
				PH_EXTRALEN: begin
					xlen_d = xlen_q | (16'(pop_item.data_byte) << {pos_q[0], 3'b000});
					pos_d  = pos_inc;
					if (pos_inc == 16'd2) begin
						pos_d   = '0;
						found_d = 1'b0;
						still_d = 1'b1;
						if (nlen_q != '0) begin
							phase_d = PH_NAME;
						end else if (xlen_d != '0) begin
							phase_d = PH_EXTRA;
						end else begin
							phase_d  = PH_END;
							status_d = zlhp_pkg::ST_COMPLETE;
						end
					end
				end
				PH_NAME: begin
					// bytes past the name length are swallowed
					if (pos_q < nlen_q) begin
						still_d = still_n;
						if (pos_ext == {11'd0, eff_len} && still_n) begin
							found_d = 1'b1;
						end
						if (pos_ext == {1'b0, nlen_q}) begin
							pos_d = '0;
							if (xlen_q == '0) begin
								phase_d  = PH_END;
								status_d = zlhp_pkg::ST_COMPLETE;
							end else begin
								phase_d = PH_EXTRA;
							end
						end else begin
							pos_d = pos_inc;
						end
					end
				end
				PH_EXTRA: begin
					pos_d = pos_inc;
					if (pos_inc == xlen_q) begin
						phase_d  = PH_END;
						status_d = zlhp_pkg::ST_COMPLETE;
					end
				end
				default: begin
					status_d = zlhp_pkg::ST_ENDED;
				end
			endcase
		end
	end

	// parser state, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_len_q  <= '0;
			name_total_q <= '0;
			for (int k = 0; k < MAX_NAME_BYTES; k++) begin
				name_q[k] <= '0;
			end
			phase_q     <= PH_SIGNATURE;
			pos_q       <= '0;
			sawl_q      <= 1'b0;
			sawc_q      <= 1'b0;
			still_q     <= 1'b1;
			found_q     <= 1'b0;
			crc_q       <= '0;
			csize_q     <= '0;
			usize_q     <= '0;
			nlen_q      <= '0;
			xlen_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == zlhp_pkg::CFG_MATCH_LEN) begin
					match_len_q <= cfg_wdata[5:0];
				end
				if (cfg_index == zlhp_pkg::CFG_NAME_TOTAL) begin
					name_total_q <= cfg_wdata[15:0];
				end
				for (int k = 0; k < MAX_NAME_BYTES; k++) begin
					if (cfg_index == zlhp_pkg::CFG_NAME_0 + 3'(k / 8)) begin
						name_q[k] <= cfg_wdata[8*(k%8) +: 8];
					end
				end
			end
			if (pop) begin
				phase_q             <= phase_d;
				pos_q               <= pos_d;
				sawl_q              <= sawl_d;
				sawc_q              <= sawc_d;
				still_q             <= still_d;
				found_q             <= found_d;
				crc_q               <= crc_d;
				csize_q             <= csize_d;
				usize_q             <= usize_d;
				nlen_q              <= nlen_d;
				xlen_q              <= xlen_d;
				res_q.status        <= status_d;
				res_q.name_matched  <= found_d;
				res_q.entry_crc     <= crc_d;
				res_q.packed_size   <= csize_d;
				res_q.plain_size    <= usize_d;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/zip_local_header_parser.sv =====
// zip_local_header_parser: top level of the zip local file header parser
// depends on zlhp_pkg, zlhp_front, zlhp_queue and zlhp_back
`default_nettype none

// The parser takes one archive byte per transaction and returns exactly one result
// per transaction. It sustains one byte per clock while nothing stalls: the front
// stage registers and classifies each byte, a short queue decouples it from the back
// part, and the back part makes one state update per byte into a result register.
// A byte passes the front stage register and the queue before its result is
// registered. Either side may stall on its own; bytes keep flowing in until the
// queue is full. Configuration registers are written through cfg_wr_en, cfg_index
// and cfg_wdata and are only to be changed while the block is idle.

module zip_local_header_parser #(
	parameter int MAX_NAME_BYTES = zlhp_pkg::MAX_NAME_BYTES_DEF,
	parameter int QUEUE_DEPTH    = zlhp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [zlhp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [zlhp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire zlhp_pkg::in_item_t               item,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output zlhp_pkg::out_item_t                   result
);

	logic                push;
	logic                pop;
	zlhp_pkg::q_item_t   push_item;
	zlhp_pkg::q_item_t   pop_item;
	zlhp_pkg::q_status_t q_stat;

	// front part
	zlhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.push_item  (push_item),
		.q_stat     (q_stat)
	);

	// decoupling queue
	zlhp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	// back part
	zlhp_back #(
		.MAX_NAME_BYTES (MAX_NAME_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.pop_item     (pop_item),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// status code stays within the defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status <= zlhp_pkg::ST_ENDED))
		else $error("result status outside the defined codes");

	// before any header is gathered the size and crc fields are still clear
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == zlhp_pkg::ST_CENTRAL
		|| result.status == zlhp_pkg::ST_METHOD)
		|-> (result.entry_crc == '0 && result.packed_size == '0
		&& result.plain_size == '0))
		else $error("header fields set before the crc phase");

	// a central directory mark is only seen with no name match pending
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == zlhp_pkg::ST_CENTRAL |-> !result.name_matched)
		else $error("name match carried into a central directory record");

	// queue cannot be full and empty together, and front pushes only with room
	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty) && !(push && q_stat.full))
		else $error("queue fill status inconsistent");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking regression of the zip local header parser
// depends on zlhp_pkg and zip_local_header_parser; byte transactions go in with random
// gaps and stalls and every result is checked against a parser model kept in the bench

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import zlhp_pkg::*;

	localparam int RESET_CYCLES   = 7;
	localparam int RESULT_LATENCY = 3;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int RANDOM_ITEMS   = 860;
	localparam int HOLD_CYCLES    = 150;
	localparam int MAX_REPORTS    = 60;
	localparam int NAME_CAP       = MAX_NAME_BYTES_DEF;

	// header parsing phases of the model
	typedef enum logic [3:0] {
		PH_SIGNATURE,
		PH_VERSION,
		PH_FLAG,
		PH_METHOD,
		PH_TIME,
		PH_DATE,
		PH_CRC,
		PH_CSIZE,
		PH_USIZE,
		PH_NAMELEN,
		PH_EXTRALEN,
		PH_NAME,
		PH_EXTRA,
		PH_END
	} hdr_phase_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_wr_en    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata    = '0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	in_item_t               item         = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	out_item_t              result;

	zip_local_header_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// model copy of the registers
	logic [5:0]   want_len   = '0;
	logic [15:0]  want_total = '0;
	logic [255:0] want_name  = '0;

	// model copy of the parser state
	hdr_phase_t  ph             = PH_SIGNATURE;
	logic [15:0] pos            = '0;
	logic        saw_local      = 1'b0;
	logic        saw_central    = 1'b0;
	logic        still_matching = 1'b1;
	logic        match_found    = 1'b0;
	logic [31:0] crc_acc        = '0;
	logic [31:0] csize_acc      = '0;
	logic [31:0] usize_acc      = '0;
	logic [15:0] name_len_field = '0;
	logic [15:0] extra_len_field = '0;

	// bench bookkeeping
	out_item_t  predicted_results[$];
	logic [7:0] entry_name[$];
	int         hdr_budget      = -1;
	bit         tx_calm         = 1'b0;
	bit         rx_calm         = 1'b0;
	logic       hold_req        = 1'b0;
	int         items_sent      = 0;
	int         results_checked = 0;
	int         headers_done    = 0;
	int         matches_seen    = 0;
	int         cfg_loads       = 0;
	int         errors          = 0;
	int         cycle_count     = 0;

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- parser model

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	function automatic logic [7:0] wanted_byte(input int i);
		return want_name[8*(i % 32) +: 8];
	endfunction

	function automatic int compare_length();
		return (want_len > NAME_CAP) ? NAME_CAP : int'(want_len);
	endfunction

	function automatic void clear_parse_state();
		ph              = PH_SIGNATURE;
		pos             = '0;
		saw_local       = 1'b0;
		saw_central     = 1'b0;
		still_matching  = 1'b1;
		match_found     = 1'b0;
		crc_acc         = '0;
		csize_acc       = '0;
		usize_acc       = '0;
		name_len_field  = '0;
		extra_len_field = '0;
	endfunction

	function automatic logic [15:0] bump_position();
		pos = pos + 16'd1;
		return pos;
	endfunction

	// one data byte through the header state machine, returns the status
	function automatic logic [2:0] parse_data_byte(input logic [7:0] b);
		logic [15:0] p;
		int          eff;
		if (want_len == 6'd0) begin
			return ST_ERROR;
		end
		case (ph)
			PH_SIGNATURE: begin
				p = bump_position();
				if (p == 16'd1 && b == BYTE_P) begin
					return ST_CONSUMED;
				end
				if (p == 16'd2 && b == BYTE_K) begin
					saw_local   = 1'b0;
					saw_central = 1'b0;
					return ST_CONSUMED;
				end
				if (p == 16'd3 && b == BYTE_03) begin
					saw_local = 1'b1;
					return ST_CONSUMED;
				end
				if (p == 16'd3 && b == BYTE_01) begin
					saw_central = 1'b1;
					return ST_CONSUMED;
				end
				if (saw_central && p == 16'd4 && b == BYTE_02) begin
					return ST_CENTRAL;
				end
				if (saw_local && p == 16'd4 && b == BYTE_04) begin
					pos = '0;
					ph  = PH_VERSION;
					return ST_CONSUMED;
				end
				return ST_ERROR;
			end
			PH_VERSION, PH_FLAG, PH_TIME, PH_DATE: begin
				if (bump_position() == 16'd2) begin
					pos = '0;
					if (ph == PH_DATE) begin
						crc_acc = '0;
					end
					ph = hdr_phase_t'(ph + 4'd1);
				end
				return ST_CONSUMED;
			end
			PH_METHOD: begin
				p = bump_position();
				if (p == 16'd1 && b != BYTE_ZERO) begin
					return ST_METHOD;
				end
				if (p == 16'd2) begin
					if (b != BYTE_ZERO) begin
						return ST_METHOD;
					end
					pos = '0;
					ph  = PH_TIME;
				end
				return ST_CONSUMED;
			end
			PH_CRC: begin
				crc_acc = crc_acc | (32'(b) << (8 * pos[1:0]));
				if (bump_position() == 16'd4) begin
					ph        = PH_CSIZE;
					csize_acc = '0;
					pos       = '0;
				end
				return ST_CONSUMED;
			end
			PH_CSIZE: begin
				csize_acc = csize_acc | (32'(b) << (8 * pos[1:0]));
				if (bump_position() == 16'd4) begin
					ph        = PH_USIZE;
					usize_acc = '0;
					pos       = '0;
				end
				return ST_CONSUMED;
			end
			PH_USIZE: begin
				usize_acc = usize_acc | (32'(b) << (8 * pos[1:0]));
				if (bump_position() == 16'd4) begin
					ph             = PH_NAMELEN;
					name_len_field = '0;
					pos            = '0;
				end
				return ST_CONSUMED;
			end
			PH_NAMELEN: begin
				name_len_field = name_len_field | (16'(b) << (8 * pos[0]));
				if (bump_position() == 16'd2) begin
					ph              = PH_EXTRALEN;
					extra_len_field = '0;
					pos             = '0;
				end
				return ST_CONSUMED;
			end
			PH_EXTRALEN: begin
				extra_len_field = extra_len_field | (16'(b) << (8 * pos[0]));
				if (bump_position() == 16'd2) begin
					pos            = '0;
					match_found    = 1'b0;
					still_matching = 1'b1;
					if (name_len_field != 16'd0) begin
						ph = PH_NAME;
					end else if (extra_len_field != 16'd0) begin
						ph = PH_EXTRA;
					end else begin
						ph = PH_END;
						return ST_COMPLETE;
					end
				end
				return ST_CONSUMED;
			end
			PH_NAME: begin
				if (pos >= name_len_field) begin
					return ST_CONSUMED;
				end
				eff = compare_length();
				if (name_len_field != want_total) begin
					still_matching = 1'b0;
				end
				if (still_matching && int'(pos) < eff &&
				    lower_ascii(wanted_byte(int'(pos))) != lower_ascii(b)) begin
					still_matching = 1'b0;
				end
				if (int'(pos) + 1 == eff && still_matching) begin
					match_found = 1'b1;
				end
				if (int'(pos) + 1 == int'(name_len_field)) begin
					pos = '0;
					if (extra_len_field == 16'd0) begin
						ph = PH_END;
						return ST_COMPLETE;
					end
					ph = PH_EXTRA;
				end else begin
					pos = pos + 16'd1;
				end
				return ST_CONSUMED;
			end
			PH_EXTRA: begin
				if (bump_position() == extra_len_field) begin
					ph = PH_END;
					return ST_COMPLETE;
				end
				return ST_CONSUMED;
			end
			default: begin
				return ST_ENDED;
			end
		endcase
	endfunction

	function automatic out_item_t predict_result(input in_item_t it);
		out_item_t r;
		if (it.func) begin
			clear_parse_state();
			r.status = ST_CONSUMED;
		end else begin
			r.status = parse_data_byte(it.data_byte);
		end
		r.name_matched = match_found;
		r.entry_crc    = crc_acc;
		r.packed_size  = csize_acc;
		r.plain_size   = usize_acc;
		return r;
	endfunction

	// ---------------------------------------------------------------- idling

	function automatic int pick_run();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 2);
		end
		if (r < 95) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_gap();
		if (tx_calm || $urandom_range(0, 99) < 55) begin
			return 0;
		end
		return pick_run();
	endfunction

	// result side stall, with a long hold-off on request
	initial begin
		int   run_left;
		int   hold_left;
		logic stall_now;
		run_left  = 0;
		hold_left = 0;
		stall_now = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					stall_now = !rx_calm && ($urandom_range(0, 99) < 35);
					run_left  = pick_run();
				end
				run_left--;
				result_stall <= stall_now;
			end
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string field, input logic [31:0] want,
	                               input logic [31:0] got);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("mismatch on result %0d: %s expected %0h got %0h",
			         results_checked, field, want, got);
		end
	endtask

	// compare each accepted result transaction with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_results.size() == 0) begin
				report_mismatch("unexpected result, status", '0, 32'(result.status));
			end else begin
				want = predicted_results.pop_front();
				if (result.status != want.status) begin
					report_mismatch("status", 32'(want.status), 32'(result.status));
				end
				if (result.name_matched != want.name_matched) begin
					report_mismatch("name_matched", 32'(want.name_matched),
					                32'(result.name_matched));
				end
				if (result.entry_crc != want.entry_crc) begin
					report_mismatch("entry_crc", want.entry_crc, result.entry_crc);
				end
				if (result.packed_size != want.packed_size) begin
					report_mismatch("packed_size", want.packed_size, result.packed_size);
				end
				if (result.plain_size != want.plain_size) begin
					report_mismatch("plain_size", want.plain_size, result.plain_size);
				end
				if (want.status == ST_COMPLETE) begin
					headers_done++;
					if (want.name_matched) begin
						matches_seen++;
					end
				end
				results_checked++;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycle_count, predicted_results.size());
			$display("zip_local_header_parser regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- drivers

	// one input transaction; valid stays high so back-to-back sends need no toggle
	task automatic send_item(input logic f, input logic [7:0] b);
		int       gap;
		in_item_t it;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.func      = f;
		it.data_byte = b;
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predicted_results.push_back(predict_result(it));
		items_sent++;
	endtask

	task automatic send_data(input logic [7:0] b);
		send_item(1'b0, b);
	endtask

	task automatic send_restart();
		send_item(1'b1, 8'($urandom));
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	// all six registers, back to back; upper data bits of the two length writes carry noise
	task automatic load_name_config(input logic [5:0] len, input logic [15:0] total,
	                                input logic [255:0] nm);
		int i;
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_MATCH_LEN;
		cfg_wdata <= {$urandom, 26'($urandom), len};
		@(posedge clk);
		want_len = len;
		cfg_index <= CFG_NAME_TOTAL;
		cfg_wdata <= {$urandom, 16'($urandom), total};
		@(posedge clk);
		want_total = total;
		for (i = 0; i < 4; i++) begin
			cfg_index <= CFG_NAME_0 + CFG_INDEX_W'(i);
			cfg_wdata <= nm[64*i +: 64];
			@(posedge clk);
			want_name[64*i +: 64] = nm[64*i +: 64];
		end
		cfg_wr_en <= 1'b0;
		cfg_loads++;
	endtask

	function automatic logic [255:0] pack_name(input string s);
		logic [255:0] bits;
		int           i;
		bits = '0;
		for (i = 0; i < s.len() && i < 32; i++) begin
			bits[8*i +: 8] = s[i];
		end
		return bits;
	endfunction

	// ---------------------------------------------------------------- header building

	task automatic send_hdr_byte(input logic [7:0] b);
		if (hdr_budget != 0) begin
			send_data(b);
			if (hdr_budget > 0) begin
				hdr_budget--;
			end
		end
	endtask

	task automatic send_hdr_le(input logic [31:0] v, input int n);
		int i;
		for (i = 0; i < n; i++) begin
			send_hdr_byte(v[8*i +: 8]);
		end
	endtask

	// local header with the name in entry_name, cut short when hdr_budget runs out
	task automatic send_header(input logic [15:0] method, input logic [31:0] crc,
	                           input logic [31:0] csz, input logic [31:0] usz,
	                           input int extra_bytes, input int trailing);
		int i;
		send_hdr_byte(BYTE_P);
		send_hdr_byte(BYTE_K);
		send_hdr_byte(BYTE_03);
		send_hdr_byte(BYTE_04);
		send_hdr_le($urandom, 4);
		send_hdr_le(32'(method), 2);
		send_hdr_le($urandom, 4);
		send_hdr_le(crc, 4);
		send_hdr_le(csz, 4);
		send_hdr_le(usz, 4);
		send_hdr_le(32'(entry_name.size()), 2);
		send_hdr_le(32'(extra_bytes), 2);
		for (i = 0; i < entry_name.size(); i++) begin
			send_hdr_byte(entry_name[i]);
		end
		for (i = 0; i < extra_bytes + trailing; i++) begin
			send_hdr_byte(8'($urandom));
		end
	endtask

	task automatic set_entry_name(input string s);
		int i;
		entry_name.delete();
		for (i = 0; i < s.len(); i++) begin
			entry_name.push_back(s[i]);
		end
	endtask

	function automatic logic [7:0] jumble_case(input logic [7:0] c);
		if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
		    $urandom_range(0, 1) == 1) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	function automatic logic [7:0] random_name_char();
		if ($urandom_range(0, 99) < 70) begin
			return jumble_case(8'h61 + 8'($urandom_range(0, 25)));
		end
		return 8'($urandom);
	endfunction

	// entry name built from the wanted name, optionally spoilt in one compared byte
	task automatic make_entry_name(input int size, input bit near_miss);
		int i;
		int eff;
		int span;
		eff = compare_length();
		entry_name.delete();
		for (i = 0; i < size; i++) begin
			entry_name.push_back((i < eff) ? jumble_case(wanted_byte(i)) : random_name_char());
		end
		span = (size < eff) ? size : eff;
		if (near_miss && span > 0) begin
			i = $urandom_range(0, span - 1);
			entry_name[i] = entry_name[i] ^ 8'h01;
		end
	endtask

	function automatic logic [255:0] random_name_bits();
		logic [255:0] bits;
		int           i;
		for (i = 0; i < 32; i++) begin
			bits[8*i +: 8] = random_name_char();
		end
		return bits;
	endfunction

	function automatic logic [15:0] pick_method();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			return 16'h0000;
		end
		if (r < 92) begin
			return 16'h0001;
		end
		if (r < 96) begin
			return 16'h0100;
		end
		return 16'($urandom_range(1, 65535));
	endfunction

	function automatic int pick_extra();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(5, 20);
	endfunction

	// ---------------------------------------------------------------- tests

	// reset registers and an explicit zero compare length reject every data byte
	task automatic test_unconfigured();
		send_data(BYTE_P);
		send_data(8'hFF);
		wait_idle();
		load_name_config(6'd0, 16'hFFFF, '1);
		send_data(BYTE_ZERO);
		send_data(BYTE_K);
		send_restart();
	endtask

	// central directory mark and broken signatures
	task automatic test_signatures();
		wait_idle();
		load_name_config(6'd9, 16'd9, pack_name("hello.bin"));
		send_restart();
		send_data(BYTE_P);
		send_data(BYTE_K);
		send_data(BYTE_01);
		send_data(BYTE_02);
		send_data(BYTE_ZERO);
		send_restart();
		send_data(BYTE_K);
		send_restart();
		send_data(BYTE_P);
		send_data(BYTE_P);
		send_restart();
		send_data(BYTE_P);
		send_data(BYTE_K);
		send_data(BYTE_03);
		send_data(BYTE_02);
		send_restart();
	endtask

	// compressed entries are rejected on either method byte
	task automatic test_methods();
		set_entry_name("hello.bin");
		send_restart();
		hdr_budget = 12;
		send_header(16'h0001, $urandom, $urandom, $urandom, 0, 0);
		send_restart();
		hdr_budget = 12;
		send_header(16'h0100, $urandom, $urandom, $urandom, 0, 0);
		hdr_budget = -1;
	endtask

	// empty entry name, with and without an extra field, then bytes after the end
	task automatic test_empty_name();
		entry_name.delete();
		send_restart();
		send_header(16'h0000, '0, '0, '0, 0, 2);
		send_restart();
		send_header(16'h0000, '1, '1, '1, 3, 1);
	endtask

	// case-blind compare, near miss, short entry name, clamped length, total mismatch
	task automatic test_name_compare();
		send_restart();
		set_entry_name("HeLLo.BIN");
		send_header(16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001, 0, 1);
		send_restart();
		set_entry_name("hello.bix");
		send_header(16'h0000, $urandom, $urandom, $urandom, 2, 0);
		wait_idle();
		load_name_config(6'd9, 16'd5, pack_name("hello.bin"));
		send_restart();
		set_entry_name("HELLO");
		send_header(16'h0000, $urandom, $urandom, $urandom, 0, 0);
		wait_idle();
		load_name_config(6'd63, 16'd32, pack_name("@AZ[`az{0123456789.-_~ABCDEFmnop"));
		send_restart();
		set_entry_name("@az[`AZ{0123456789.-_~abcdefMNOP");
		send_header(16'h0000, $urandom, $urandom, $urandom, 1, 0);
		wait_idle();
		load_name_config(6'd32, 16'hFFFF, pack_name("@AZ[`az{0123456789.-_~ABCDEFmnop"));
		send_restart();
		send_header(16'h0000, $urandom, $urandom, $urandom, 0, 0);
	endtask

	// result side holds off while the sender keeps offering
	task automatic test_backpressure();
		int k;
		wait_idle();
		load_name_config(6'd4, 16'd8, pack_name("data.bin"));
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		tx_calm = 1'b1;
		for (k = 0; k < 3; k++) begin
			send_restart();
			set_entry_name("DATA.BIN");
			send_header(16'h0000, $urandom, $urandom, $urandom, 2, 0);
		end
		tx_calm = 1'b0;
	endtask

	task automatic random_config();
		logic [5:0] len;
		int         eff;
		int         total;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			len = 6'd0;
		end else if (r < 10) begin
			len = 6'd63;
		end else if (r < 16) begin
			len = 6'd32;
		end else if (r < 20) begin
			len = 6'($urandom_range(33, 62));
		end else begin
			len = 6'($urandom_range(1, 10));
		end
		eff = (len > NAME_CAP) ? NAME_CAP : int'(len);
		r = $urandom_range(0, 99);
		if (r < 10) begin
			total = $urandom_range(0, 65535);
		end else if (r < 20 && eff > 0) begin
			total = $urandom_range(0, eff - 1);
		end else begin
			total = eff + $urandom_range(0, 6);
		end
		load_name_config(len, 16'(total), random_name_bits());
	endtask

	// one random stretch: mostly well formed headers, some noise and broken records
	task automatic random_entry();
		int r;
		int k;
		if ($urandom_range(0, 9) == 0) begin
			tx_calm = !tx_calm;
		end
		if ($urandom_range(0, 9) == 0) begin
			rx_calm = !rx_calm;
		end
		if ($urandom_range(0, 9) != 0) begin
			send_restart();
		end
		r = $urandom_range(0, 99);
		if (r < 70 || r >= 88) begin
			k = $urandom_range(0, 99);
			if (want_total <= 16'd48 && k < 60) begin
				make_entry_name(int'(want_total), 1'b0);
			end else if (want_total <= 16'd48 && k < 75) begin
				make_entry_name(int'(want_total), 1'b1);
			end else if (k < 85) begin
				entry_name.delete();
			end else begin
				make_entry_name($urandom_range(1, 12), 1'($urandom_range(0, 1)));
			end
			// broken header: cut off somewhere inside
			hdr_budget = (r >= 88) ? $urandom_range(1, 30) : -1;
			send_header(pick_method(), $urandom, $urandom, $urandom, pick_extra(),
			            $urandom_range(0, 2));
			hdr_budget = -1;
		end else if (r < 78) begin
			send_data(BYTE_P);
			send_data(BYTE_K);
			send_data(BYTE_01);
			send_data(BYTE_02);
			repeat ($urandom_range(0, 2)) send_data(8'($urandom));
		end else begin
			if ($urandom_range(0, 1) == 1) begin
				send_data(BYTE_P);
				send_data(BYTE_K);
			end
			repeat ($urandom_range(1, 8)) send_data(8'($urandom));
		end
	endtask

	task automatic test_random();
		int first;
		int n;
		int k;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			wait_idle();
			random_config();
			n = $urandom_range(3, 8);
			for (k = 0; k < n && items_sent - first < RANDOM_ITEMS; k++) begin
				random_entry();
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_unconfigured();
		test_signatures();
		test_methods();
		test_empty_name();
		test_name_compare();
		test_backpressure();
		test_random();
		wait_idle();
		$display("covered %0d byte transactions and %0d results, %0d headers completed (%0d matched)",
		         items_sent, results_checked, headers_done, matches_seen);
		$display("%0d register loads, %0d mismatches, %0d cycles",
		         cfg_loads, errors, cycle_count);
		if (errors == 0) begin
			$display("zip_local_header_parser regression: pass");
		end else begin
			$display("zip_local_header_parser regression: fail");
		end
		$finish;
	end

endmodule

// ===== zip_local_header_parser.f =====
src/zlhp_pkg.sv
src/zlhp_front.sv
src/zlhp_queue.sv
src/zlhp_back.sv
src/zip_local_header_parser.sv
bench/testbench.sv
